// File: sv/unat_pkg.sv
// Shared types and constants of the UDP address and port translation table.
package unat_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LOCAL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd300;
  localparam logic [15:0] PORT_BASE_RST    = 16'd40000;
  localparam logic [15:0] PORT_LIMIT_RST   = 16'd50000;

  localparam logic [1:0] REG_PUBLIC_IP    = 2'd0;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PORT_BASE    = 2'd2;
  localparam logic [1:0] REG_PORT_LIMIT   = 2'd3;

  typedef struct packed {
    logic        func;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [2:0]  arrival_iface;
    logic [31:0] now_time;
  } unat_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_addr;
    logic [15:0] new_port;
    logic [2:0]  out_iface;
  } unat_out_t;

  typedef struct packed {
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [31:0] mapped_addr;
    logic [15:0] mapped_port;
    logic [31:0] inside_addr;
    logic [15:0] inside_port;
    logic [31:0] last_seen;
    logic [2:0]  inside_iface;
  } unat_entry_t;

  typedef struct packed {
    logic [31:0] public_ip;
    logic [31:0] idle_timeout;
    logic [15:0] port_base;
    logic [15:0] port_limit;
  } unat_cfg_t;

endpackage

// File: sv/unat_cfg_regs.sv
// APB configuration registers of the translation table.
module unat_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output unat_pkg::unat_cfg_t cfg
);
  import unat_pkg::*;

  unat_cfg_t cfg_r;
  logic      wr;

  assign wr  = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.public_ip    <= '0;
      cfg_r.idle_timeout <= IDLE_TIMEOUT_RST;
      cfg_r.port_base    <= PORT_BASE_RST;
      cfg_r.port_limit   <= PORT_LIMIT_RST;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_PUBLIC_IP:    cfg_r.public_ip    <= pwdata;
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout <= pwdata;
        REG_PORT_BASE:    cfg_r.port_base    <= pwdata[15:0];
        REG_PORT_LIMIT:   cfg_r.port_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_PUBLIC_IP:    prdata = cfg_r.public_ip;
      REG_IDLE_TIMEOUT: prdata = cfg_r.idle_timeout;
      REG_PORT_BASE:    prdata = {16'd0, cfg_r.port_base};
      REG_PORT_LIMIT:   prdata = {16'd0, cfg_r.port_limit};
      default:          prdata = '0;
    endcase
  end
endmodule

// File: sv/unat_engine.sv
// Sequencer that scans the table, ages entries and allocates public ports.
module unat_engine #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  unat_pkg::unat_in_t   req,
  input  unat_pkg::unat_cfg_t  cfg,
  output logic                 busy,
  output logic                 done,
  output unat_pkg::unat_out_t  res
);
  import unat_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_ADV   = 7'b0001000,
    S_PORT  = 7'b0010000,
    S_PCHK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  unat_entry_t mem [TABLE_ENTRIES];
  unat_entry_t rd_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  unat_in_t  req_r;
  unat_out_t res_r;
  logic [IW:0] idx_r;           // entry being read; extra bit marks end of sweep
  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] free_r;
  logic          free_ok_r;
  logic [15:0]   cnt_r;
  logic [CW-1:0] tries_r;
  logic          inuse_r;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  unat_entry_t   wr_data;

  logic          rd_valid, match, expire, port_hit;
  logic [15:0]   cnt_inc;
  logic [31:0]   age;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

  assign rd_valid = valid_r[rd_idx_r];
  assign age      = req_r.now_time - rd_r.last_seen;
  assign expire   = age > cfg.idle_timeout;
  assign port_hit = rd_valid && (rd_r.mapped_port == cnt_r);
  assign cnt_inc  = (cnt_r + 16'd1 >= cfg.port_limit) ? cfg.port_base : cnt_r + 16'd1;

  always_comb begin
    if (!req_r.func)
      match = req_r.src_ip == rd_r.inside_addr && req_r.dst_ip == rd_r.remote_addr &&
              req_r.src_port == rd_r.inside_port && req_r.dst_port == rd_r.remote_port;
    else
      match = req_r.src_ip == rd_r.remote_addr && req_r.dst_ip == rd_r.mapped_addr &&
              req_r.src_port == rd_r.remote_port && req_r.dst_port == rd_r.mapped_port;
  end

  // Table memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_r <= mem[idx_r[IW-1:0]];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = rd_idx_r;
    wr_data = rd_r;
    if (state_r == S_CHECK && rd_valid && match) begin
      wr_en             = 1'b1;
      wr_data.last_seen = req_r.now_time;
    end else if (state_r == S_PCHK && !inuse_r && !port_hit
                 && idx_r == LAST + 1'b1) begin
      wr_en   = 1'b1;
      wr_idx  = free_r;
      wr_data = '{remote_addr: req_r.dst_ip, remote_port: req_r.dst_port,
                  mapped_addr: cfg.public_ip, mapped_port: cnt_r,
                  inside_addr: req_r.src_ip, inside_port: req_r.src_port,
                  last_seen: req_r.now_time, inside_iface: req_r.arrival_iface};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (rd_valid && match) begin
          state_nxt = S_DONE;
        end else if ({1'b0, rd_idx_r} == LAST) begin
          if (req_r.func || (!free_ok_r && rd_valid && !expire)) state_nxt = S_DONE;
          else state_nxt = S_ADV;
        end
      end
      S_ADV:   state_nxt = S_PORT;
      S_PORT:  state_nxt = S_PCHK;
      S_PCHK:  begin
        if ({1'b0, rd_idx_r} == LAST) begin
          if (!(inuse_r || port_hit) || tries_r == CW'(TABLE_ENTRIES)) state_nxt = S_DONE;
          else state_nxt = S_PORT;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control sequencing; a sweep visits the entries in index order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      cnt_r   <= PORT_BASE_RST;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (start) begin
          req_r     <= req;
          idx_r     <= '0;
          free_ok_r <= 1'b0;
          res_r     <= '{status: ST_OK, new_addr: '0, new_port: '0, out_iface: '0};
        end
        S_SCAN: begin
          rd_idx_r <= idx_r[IW-1:0];
          idx_r    <= idx_r + 1'b1;
        end
        S_CHECK: begin
          rd_idx_r <= idx_r[IW-1:0];
          idx_r    <= idx_r + 1'b1;
          if (rd_valid && match) begin
            if (req_r.func) begin
              res_r.new_addr  <= rd_r.inside_addr;
              res_r.new_port  <= rd_r.inside_port;
              res_r.out_iface <= rd_r.inside_iface;
            end else begin
              res_r.new_addr <= rd_r.mapped_addr;
              res_r.new_port <= rd_r.mapped_port;
            end
          end else begin
            if (!rd_valid || expire) begin
              valid_r[rd_idx_r] <= 1'b0;
              if (!free_ok_r) begin
                free_r    <= rd_idx_r;
                free_ok_r <= 1'b1;
              end
            end
            if ({1'b0, rd_idx_r} == LAST) begin
              if (req_r.func) begin
                res_r.status <= ST_LOCAL;
              end else if (!free_ok_r && rd_valid && !expire) begin
                res_r.status <= ST_FULL;
              end
            end
          end
        end
        S_ADV: begin
          cnt_r   <= cnt_inc;
          tries_r <= '0;
          idx_r   <= '0;
        end
        S_PORT: begin
          inuse_r  <= 1'b0;
          rd_idx_r <= idx_r[IW-1:0];
          idx_r    <= idx_r + 1'b1;
        end
        S_PCHK: begin
          rd_idx_r <= idx_r[IW-1:0];
          if (port_hit) inuse_r <= 1'b1;
          if ({1'b0, rd_idx_r} == LAST) begin
            idx_r <= '0;
            if (!(inuse_r || port_hit)) begin
              valid_r[free_r]  <= 1'b1;
              res_r.new_addr   <= cfg.public_ip;
              res_r.new_port   <= cnt_r;
            end else if (tries_r == CW'(TABLE_ENTRIES)) begin
              res_r.status <= ST_FULL;
            end else begin
              cnt_r   <= cnt_inc;
              tries_r <= tries_r + 1'b1;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end
endmodule

// File: sv/udp_nat_translation_table.sv
// Top level of the UDP address and port translation table.
// Usage:
//   Pulse in_start with an in_req header while busy is low; the request is
//   taken at that edge and busy stays high until the result is shown.
//   One result per request appears on out_res for exactly one cycle,
//   marked by out_valid; the receiver cannot stall it.
// Lookup: a lookup sweeps the table once, one entry per cycle through the
//   single read port of the entry memory (S_SCAN, then S_CHECK); a hit
//   ends the sweep at the matching entry. An outbound miss with a free or
//   expired entry then passes S_ADV and sweeps the table once more per
//   public port tried (S_PORT, then S_PCHK), at most TABLE_ENTRIES+1 tries.
// Next request: busy drops the cycle after out_valid, so the next request can
//   be taken then; no new request is taken while busy is high.
// Configuration: APB writes to public_ip (0x0), idle_timeout (0x4), port_base (0x8),
//   port_limit (0xC); the user must write only while the block is idle (unenforced).
// Reset: rst_n low clears all entry valid bits at once, sets the port
//   counter to 40000 and the registers to their defaults; no clearing pass.
module udp_nat_translation_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NUM_IFACES    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  unat_pkg::unat_in_t  in_req,
  output logic                busy,
  output logic                out_valid,
  output unat_pkg::unat_out_t out_res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import unat_pkg::*;

  unat_cfg_t cfg;
  unat_in_t  req;

  assign pready = 1'b1;

  // Interface index is kept as the full 3-bit field; it is zeroed only if NUM_IFACES is below 1.
  always_comb begin
    req = in_req;
    if (NUM_IFACES < 1) req.arrival_iface = '0;
  end

  unat_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  unat_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_eng (
    .clk, .rst_n, .start(in_start), .req, .cfg, .busy, .done(out_valid), .res(out_res)
  );
endmodule

// File: sv/unat_checker.sv
// Port-level checker for the translation table, bound to the top level.
module unat_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_start,
  input logic                busy,
  input logic                out_valid,
  input unat_pkg::unat_out_t out_res
);
  import unat_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && !busy |=> busy) else $error("request not taken");
  a_valid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside request");
  a_idle_after_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("result not single");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.status <= ST_FULL) else $error("bad status");
  a_no_xlate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_OK |-> out_res.new_addr == '0 && out_res.new_port == '0)
    else $error("untranslated result carries data");
endmodule

bind udp_nat_translation_table unat_port_checker u_chk (
  .clk, .rst_n, .in_start, .busy, .out_valid, .out_res
);
